### design/glf_pkg.sv
// Shared types and constants for the Lax-Friedrichs flux splitting block.
package glf_pkg;

	localparam int DATA_W      = 32;
	localparam int GHOST_W     = 4;
	localparam int IDX_W       = 6;
	localparam int IN_TDATA_W  = 192;
	localparam int OUT_TDATA_W = 200;
	localparam int WIDE_W      = 64;

	localparam logic [GHOST_W-1:0] GHOST_RESET = 4'd2;

	localparam logic signed [WIDE_W-1:0] SAT_MAX_W = 64'sd2147483647;
	localparam logic signed [WIDE_W-1:0] SAT_MIN_W = -64'sd2147483648;

	// One stored cell: conserved variables, primitives and its wave speed.
	typedef struct packed {
		logic signed [DATA_W-1:0] rho;
		logic signed [DATA_W-1:0] mom;
		logic signed [DATA_W-1:0] ener;
		logic signed [DATA_W-1:0] vel;
		logic signed [DATA_W-1:0] pres;
		logic signed [DATA_W-1:0] ws;
	} cell_t;

	// Operations of the shared add and saturate unit.
	typedef enum logic [1:0] {
		ALU_ADD  = 2'd0,
		ALU_HALF = 2'd1,
		ALU_SUB  = 2'd2
	} alu_op_t;

	// Sign-extend a 32-bit value to the wide datapath.
	function automatic logic signed [WIDE_W-1:0] sx_wide(input logic signed [DATA_W-1:0] v);
		sx_wide = {{(WIDE_W-DATA_W){v[DATA_W-1]}}, v};
	endfunction

endpackage

### design/glf_cellmem.sv
// Cell memory: one write port and one registered read port.
module glf_cellmem
	import glf_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  cell_t         wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output cell_t         rdata
);

	cell_t mem_q [DEPTH];
	cell_t rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/glf_mul.sv
// Shared signed 32x32 multiplier with a registered product.
module glf_mul
	import glf_pkg::*;
(
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [DATA_W-1:0] a,
	input  logic signed [DATA_W-1:0] b,
	output logic signed [WIDE_W-1:0] prod
);

	logic signed [WIDE_W-1:0] prod_q;

	// The product holds until the next issue.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= sx_wide(a) * sx_wide(b);
		end
	end

	assign prod = prod_q;

endmodule

### design/glf_alu.sv
// Shared add, subtract and halve unit with saturation to 32 bits.
module glf_alu
	import glf_pkg::*;
(
	input  alu_op_t                  op,
	input  logic signed [WIDE_W-1:0] x,
	input  logic signed [WIDE_W-1:0] y,
	output logic signed [DATA_W-1:0] res
);

	logic signed [WIDE_W-1:0] sum;
	logic signed [WIDE_W-1:0] scaled;

	// Exact sum or difference, then an optional floor halving.
	always_comb begin
		case (op)
			ALU_SUB: sum = x - y;
			default: sum = x + y;
		endcase
		scaled = (op == ALU_HALF) ? (sum >>> 1) : sum;
	end

	// Clamp to the signed 32-bit range.
	always_comb begin
		if (scaled > SAT_MAX_W) begin
			res = SAT_MAX_W[DATA_W-1:0];
		end else if (scaled < SAT_MIN_W) begin
			res = SAT_MIN_W[DATA_W-1:0];
		end else begin
			res = scaled[DATA_W-1:0];
		end
	end

endmodule

### design/global_lax_friedrichs_flux_split.sv
// Top level of the global Lax-Friedrichs flux vector splitting block.
//
// A row of cells streams in on s_axis; each transaction is captured, then its wave speed
// is computed and stored, and tlast closes the row. The block then scans the interior
// wave speeds, one memory read per cycle, reading none if the row has no interior cells.
// It then emits one flux pair per cell on m_axis: each cell is read, passes the steps MU,
// F2, F3, P1, M1, P2, M2, P3 and M3, and waits for a ready receiver. One shared multiplier
// is issued five times and one shared add/saturate unit is used nine times per cell.
// The block takes no input while a row is being scanned or emitted. Memory contents need
// no clearing after reset, since only cells written in the current row are read.
module global_lax_friedrichs_flux_split
	import glf_pkg::*;
#(
	parameter int MAX_CELLS = 64,
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Configuration: ghost_cells.
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [GHOST_W-1:0]     cfg_data,
	// Input: density, momentum, total_energy, velocity, pressure, sound_speed.
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                   s_axis_tlast,
	// Output: cell_index, plus_mass, plus_momentum, plus_energy, minus_mass,
	// minus_momentum, minus_energy, then zero padding.
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	output logic                   m_axis_tlast
);

	localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
	localparam int CW = $clog2(MAX_CELLS + 1);
	localparam int SW = ((CW > GHOST_W) ? CW : GHOST_W) + 1;

	typedef enum logic [13:0] {
		ST_IDLE = 14'b00000000000001,
		ST_LOAD = 14'b00000000000010,
		ST_SCAN = 14'b00000000000100,
		ST_READ = 14'b00000000001000,
		ST_MU   = 14'b00000000010000,
		ST_F2   = 14'b00000000100000,
		ST_F3   = 14'b00000001000000,
		ST_P1   = 14'b00000010000000,
		ST_M1   = 14'b00000100000000,
		ST_P2   = 14'b00001000000000,
		ST_M2   = 14'b00010000000000,
		ST_P3   = 14'b00100000000000,
		ST_M3   = 14'b01000000000000,
		ST_OUT  = 14'b10000000000000
	} state_t;

	state_t state_q;

	logic [GHOST_W-1:0] ghost_q;
	logic [CW-1:0]      cnt_q;
	logic [SW-1:0]      idx_q;
	logic               pend_q;
	logic [AW-1:0]      cell_q;
	logic signed [DATA_W-1:0] alpha_q;

	// Captured input cell.
	logic signed [DATA_W-1:0] in_rho_q, in_mom_q, in_ener_q, in_vel_q, in_pres_q, in_snd_q;
	logic                     in_last_q;

	// Intermediate flux terms.
	logic signed [DATA_W-1:0] eps_q, f2_q, f3_q;
	logic signed [DATA_W-1:0] fp_q [3];
	logic signed [DATA_W-1:0] fm_q [3];

	// Output register.
	logic                   ov_q;
	logic [OUT_TDATA_W-1:0] odata_q;
	logic                   olast_q;

	logic in_acc, out_load, store_we, mem_re, scan_go, cell_final;
	logic [SW-1:0] hi_w;
	cell_t wr_cell, rd_cell;
	logic [AW-1:0] mem_raddr;

	logic signed [DATA_W:0] ws_sum, ws_dif, ws_u;
	logic [DATA_W:0] abs_u, abs_s, abs_d, ws_max;
	logic signed [DATA_W-1:0] ws_sat;

	logic mul_en;
	logic signed [DATA_W-1:0] mul_a, mul_b;
	logic signed [WIDE_W-1:0] prod, prod_sh;

	alu_op_t alu_op;
	logic signed [WIDE_W-1:0] alu_x, alu_y;
	logic signed [DATA_W-1:0] alu_res;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_load      = (state_q == ST_OUT) && (!ov_q || m_axis_tready);
	assign cell_final    = ((CW'(cell_q) + CW'(1)) == cnt_q);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ghost_q <= GHOST_RESET;
		end else if (cfg_valid && cfg_ready) begin
			ghost_q <= cfg_data;
		end
	end

	// Input capture.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			in_rho_q  <= s_axis_tdata[31:0];
			in_mom_q  <= s_axis_tdata[63:32];
			in_ener_q <= s_axis_tdata[95:64];
			in_vel_q  <= s_axis_tdata[127:96];
			in_pres_q <= s_axis_tdata[159:128];
			in_snd_q  <= s_axis_tdata[191:160];
			in_last_q <= s_axis_tlast;
		end
	end

	// Wave speed max(|u|, |u+a|, |u-a|), saturated.
	always_comb begin
		ws_u   = {in_vel_q[DATA_W-1], in_vel_q};
		ws_sum = ws_u + {in_snd_q[DATA_W-1], in_snd_q};
		ws_dif = ws_u - {in_snd_q[DATA_W-1], in_snd_q};
		abs_u  = ws_u[DATA_W] ? (DATA_W+1)'(-ws_u) : ws_u;
		abs_s  = ws_sum[DATA_W] ? (DATA_W+1)'(-ws_sum) : ws_sum;
		abs_d  = ws_dif[DATA_W] ? (DATA_W+1)'(-ws_dif) : ws_dif;
		ws_max = abs_u;
		if (abs_s > ws_max) begin
			ws_max = abs_s;
		end
		if (abs_d > ws_max) begin
			ws_max = abs_d;
		end
		if (ws_max > (DATA_W+1)'(SAT_MAX_W)) begin
			ws_sat = SAT_MAX_W[DATA_W-1:0];
		end else begin
			ws_sat = ws_max[DATA_W-1:0];
		end
	end

	// Cell memory write and read selection.
	assign store_we = (state_q == ST_LOAD) && (cnt_q < CW'(MAX_CELLS));
	assign wr_cell  = '{rho: in_rho_q, mom: in_mom_q, ener: in_ener_q,
		vel: in_vel_q, pres: in_pres_q, ws: ws_sat};
	assign hi_w     = (SW'(cnt_q) > (SW'(ghost_q) << 1)) ? (SW'(cnt_q) - SW'(ghost_q))
		: SW'(ghost_q);
	assign scan_go  = (state_q == ST_SCAN) && (idx_q < hi_w);
	assign mem_re   = scan_go || (state_q == ST_READ);
	assign mem_raddr = (state_q == ST_SCAN) ? idx_q[AW-1:0] : cell_q;

	glf_cellmem #(
		.DEPTH(MAX_CELLS),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (store_we),
		.waddr(cnt_q[AW-1:0]),
		.wdata(wr_cell),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(rd_cell)
	);

	// Multiplier operand selection per step.
	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			ST_MU: begin
				mul_a = rd_cell.mom;
				mul_b = rd_cell.vel;
			end
			ST_F2: begin
				mul_a = rd_cell.vel;
				mul_b = eps_q;
			end
			ST_F3: begin
				mul_a = alpha_q;
				mul_b = rd_cell.rho;
			end
			ST_P1: begin
				mul_a = alpha_q;
				mul_b = rd_cell.mom;
			end
			ST_P2: begin
				mul_a = alpha_q;
				mul_b = rd_cell.ener;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	glf_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.prod(prod)
	);

	// Products are scaled back with a floor shift.
	assign prod_sh = prod >>> FRAC_BITS;

	// Add unit operand selection per step.
	always_comb begin
		alu_op = ALU_ADD;
		alu_x  = '0;
		alu_y  = '0;
		case (state_q)
			ST_MU: begin
				alu_x = sx_wide(rd_cell.ener);
				alu_y = sx_wide(rd_cell.pres);
			end
			ST_F2: begin
				alu_x = prod_sh;
				alu_y = sx_wide(rd_cell.pres);
			end
			ST_F3: begin
				alu_x = prod_sh;
			end
			ST_P1: begin
				alu_op = ALU_HALF;
				alu_x  = prod_sh;
				alu_y  = sx_wide(rd_cell.mom);
			end
			ST_M1: begin
				alu_op = ALU_SUB;
				alu_x  = sx_wide(rd_cell.mom);
				alu_y  = sx_wide(fp_q[0]);
			end
			ST_P2: begin
				alu_op = ALU_HALF;
				alu_x  = prod_sh;
				alu_y  = sx_wide(f2_q);
			end
			ST_M2: begin
				alu_op = ALU_SUB;
				alu_x  = sx_wide(f2_q);
				alu_y  = sx_wide(fp_q[1]);
			end
			ST_P3: begin
				alu_op = ALU_HALF;
				alu_x  = prod_sh;
				alu_y  = sx_wide(f3_q);
			end
			ST_M3: begin
				alu_op = ALU_SUB;
				alu_x  = sx_wide(f3_q);
				alu_y  = sx_wide(fp_q[2]);
			end
			default: begin
				alu_op = ALU_ADD;
			end
		endcase
	end

	glf_alu u_alu (
		.op (alu_op),
		.x  (alu_x),
		.y  (alu_y),
		.res(alu_res)
	);

	// Capture the unit's result into the register of the current step.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_MU:   eps_q   <= alu_res;
			ST_F2:   f2_q    <= alu_res;
			ST_F3:   f3_q    <= alu_res;
			ST_P1:   fp_q[0] <= alu_res;
			ST_M1:   fm_q[0] <= alu_res;
			ST_P2:   fp_q[1] <= alu_res;
			ST_M2:   fm_q[1] <= alu_res;
			ST_P3:   fp_q[2] <= alu_res;
			ST_M3:   fm_q[2] <= alu_res;
			default: eps_q   <= eps_q;
		endcase
	end

	// Sequencer: load, scan for alpha, then emit cell by cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
			pend_q  <= 1'b0;
			cell_q  <= '0;
			alpha_q <= '0;
		end else begin
			// Running maximum of the wave speeds read during the scan.
			if (pend_q && (rd_cell.ws > alpha_q)) begin
				alpha_q <= rd_cell.ws;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (store_we) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (in_last_q) begin
						idx_q   <= SW'(ghost_q);
						pend_q  <= 1'b0;
						alpha_q <= '0;
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (scan_go) begin
						idx_q  <= idx_q + SW'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q  <= 1'b0;
						cell_q  <= '0;
						state_q <= ST_READ;
					end
				end
				ST_READ: state_q <= ST_MU;
				ST_MU:   state_q <= ST_F2;
				ST_F2:   state_q <= ST_F3;
				ST_F3:   state_q <= ST_P1;
				ST_P1:   state_q <= ST_M1;
				ST_M1:   state_q <= ST_P2;
				ST_P2:   state_q <= ST_M2;
				ST_M2:   state_q <= ST_P3;
				ST_P3:   state_q <= ST_M3;
				ST_M3:   state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) begin
						if (cell_final) begin
							cnt_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							cell_q  <= cell_q + AW'(1);
							state_q <= ST_READ;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (out_load) begin
			ov_q <= 1'b1;
		end else if (m_axis_tready) begin
			ov_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			odata_q <= {2'b00, fm_q[2], fm_q[1], fm_q[0], fp_q[2], fp_q[1], fp_q[0],
				IDX_W'(cell_q)};
			olast_q <= cell_final;
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = odata_q;
	assign m_axis_tlast  = olast_q;

endmodule

### design/glf_checker.sv
// Port-level checks for the flux splitting block, bound to the top level.
module glf_checker
	import glf_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                   m_axis_tlast
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// An accepted input transaction leaves the block busy, so inputs are never accepted back to back.
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted on back-to-back cycles");

	// After the last result of a row no result follows at once.
	a_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
		else $error("result follows the end of a row");

	// The padding bits of a result are zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:OUT_TDATA_W-2] == 2'b00)
		else $error("nonzero padding in result");

endmodule

bind global_lax_friedrichs_flux_split glf_checker u_glf_checker (.*);
